// ===== rtl/rat_pkg.sv =====
// ---------------------------------------------------------------------------
// rat_pkg
// shared types and constants for the rational add/multiply/reduce block
// ---------------------------------------------------------------------------
package rat_pkg;

    // operation codes
    typedef enum logic [1:0] {
        KIND_MAKE = 2'd0,
        KIND_ADD  = 2'd1,
        KIND_MUL  = 2'd2,
        KIND_CMP  = 2'd3
    } kind_t;

    // width of the raw fraction fields handed to the back end
    localparam int RAW_BITS = 64;

    // back end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SUM,
        BK_GCD,
        BK_DIVN,
        BK_DIVD,
        BK_DONE
    } bk_state_t;

    // command passed from front to back through the queue
    typedef struct packed {
        kind_t       kind;
        logic [63:0] an;
        logic [63:0] ad;
        logic [63:0] bn;
        logic [63:0] bd;
    } cmd_t;

endpackage

// ===== rtl/rat_divider.sv =====
// ---------------------------------------------------------------------------
// rat_divider
// restoring divider, one quotient bit per cycle, unsigned 64-bit operands
// ---------------------------------------------------------------------------
module rat_divider
    import rat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [63:0] remainder
);

    logic        run_reg;
    logic        run_next;
    logic [6:0]  cnt_reg;
    logic [6:0]  cnt_next;
    logic [63:0] q_reg;
    logic [63:0] q_next;
    logic [64:0] r_reg;
    logic [64:0] r_next;
    logic [63:0] d_reg;
    logic [63:0] d_next;
    logic        done_reg;
    logic        done_next;
    logic [64:0] shifted;
    logic [64:0] trial;

    // one shift-subtract step per cycle
    always_comb
    begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        done_next = 1'b0;
        shifted   = {r_reg[63:0], q_reg[63]};
        trial     = shifted - {1'b0, d_reg};
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = 7'd0;
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
        end
        else if (run_reg)
        begin
            if (!trial[64])
            begin
                r_next = trial;
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg[63:0];

endmodule

// ===== rtl/rat_front.sv =====
// ---------------------------------------------------------------------------
// rat_front
// accepts commands, settles compares at once, queues arithmetic for the back
// ---------------------------------------------------------------------------
module rat_front
    import rat_pkg::*;
#(
    parameter int OPERAND_BITS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     kind,
    input  logic signed [OPERAND_BITS-1:0] a_num,
    input  logic signed [OPERAND_BITS-1:0] a_den,
    input  logic signed [OPERAND_BITS-1:0] b_num,
    input  logic signed [OPERAND_BITS-1:0] b_den,
    output logic                           q_valid,
    output cmd_t                           q_cmd,
    input  logic                           q_pop,
    input  logic                           back_idle,
    output logic                           cmp_strobe,
    output logic                           cmp_eq,
    output logic                           cmp_ne
);

    logic  full_reg;
    logic  cmp_reg;
    logic  eq_reg;
    logic  ne_reg;
    cmd_t  cmd_reg;
    logic  xfer;
    logic  match;
    logic  any_empty;

    // one item in flight at a time: queue slot, back end or compare strobe occupied
    assign busy = full_reg || !back_idle || cmp_reg;
    assign xfer = start && !busy;

    assign match     = (a_num == b_num) && (a_den == b_den);
    assign any_empty = (a_num == '1) || (b_num == '1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            cmp_reg  <= 1'b0;
        end
        else
        begin
            cmp_reg <= xfer && (kind == KIND_CMP);
            if (xfer && (kind != KIND_CMP))
                full_reg <= 1'b1;
            else if (q_pop)
                full_reg <= 1'b0;
        end
    end

    // queue slot payload, sign extended to the raw width
    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            cmd_reg.kind <= kind_t'(kind);
            cmd_reg.an   <= 64'(a_num);
            cmd_reg.ad   <= 64'(a_den);
            cmd_reg.bn   <= 64'(b_num);
            cmd_reg.bd   <= 64'(b_den);
            eq_reg       <= !any_empty && match;
            ne_reg       <= !any_empty && !match;
        end
    end

    assign q_valid    = full_reg;
    assign q_cmd      = cmd_reg;
    assign cmp_strobe = cmp_reg;
    assign cmp_eq     = eq_reg;
    assign cmp_ne     = ne_reg;

    property p_one_in_flight;
        @(posedge clk) disable iff (!rst_n)
        !(cmp_reg && full_reg);
    endproperty
    a_one_in_flight: assert property (p_one_in_flight)
        else $error("compare and arithmetic in flight together");

endmodule

// ===== rtl/rat_back.sv =====
// ---------------------------------------------------------------------------
// rat_back
// forms the raw fraction, runs euclid on a shared divider, then reduces
// ---------------------------------------------------------------------------
module rat_back
    import rat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        idle,
    output logic        res_strobe,
    output logic [31:0] res_num,
    output logic [30:0] res_den,
    output logic        empty_res
);

    bk_state_t   state_reg;
    bk_state_t   state_next;
    cmd_t        cmd_reg;
    cmd_t        cmd_next;
    logic [63:0] p0_reg;
    logic [63:0] p0_next;
    logic [63:0] p1_reg;
    logic [63:0] p1_next;
    logic [63:0] n_reg;
    logic [63:0] n_next;
    logic [63:0] d_reg;
    logic [63:0] d_next;
    logic [63:0] gx_reg;
    logic [63:0] gx_next;
    logic [63:0] gy_reg;
    logic [63:0] gy_next;
    logic [63:0] rn_reg;
    logic [63:0] rn_next;
    logic        busy_div_reg;
    logic        busy_div_next;
    logic        go;
    logic [63:0] div_a;
    logic [63:0] div_b;
    logic        div_done;
    logic [63:0] div_q;
    logic [63:0] div_r;
    logic        out_reg;
    logic        out_next;
    logic [31:0] on_reg;
    logic [31:0] on_next;
    logic [30:0] od_reg;
    logic [30:0] od_next;
    logic        oe_reg;
    logic        oe_next;
    logic        raw_ok;
    logic signed [31:0] m_an;
    logic signed [31:0] m_ad;
    logic signed [31:0] m_bn;
    logic signed [31:0] m_bd;
    logic signed [31:0] m_sel;
    logic signed [63:0] prod0;
    logic signed [63:0] prod1;
    logic signed [63:0] prod2;

    rat_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign raw_ok = !n_reg[63] && !d_reg[63] && (d_reg != 64'd0);

    // operands hold at most 31 significant bits, so 32x32 signed products suffice
    assign m_an  = cmd_reg.an[31:0];
    assign m_ad  = cmd_reg.ad[31:0];
    assign m_bn  = cmd_reg.bn[31:0];
    assign m_bd  = cmd_reg.bd[31:0];
    assign m_sel = (cmd_reg.kind == KIND_MUL) ? m_an : m_ad;
    assign prod0 = m_bn * m_sel;
    assign prod1 = m_bd * m_an;
    assign prod2 = m_bd * m_ad;

    // sequencer: multiply, sum, euclid loop, two divisions
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        p0_next       = p0_reg;
        p1_next       = p1_reg;
        n_next        = n_reg;
        d_next        = d_reg;
        gx_next       = gx_reg;
        gy_next       = gy_reg;
        rn_next       = rn_reg;
        busy_div_next = busy_div_reg;
        go            = 1'b0;
        div_a         = gx_reg;
        div_b         = gy_reg;
        q_pop         = 1'b0;
        out_next      = 1'b0;
        on_next       = on_reg;
        od_next       = od_reg;
        oe_next       = oe_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                // cross products of the raw operands
                p0_next = prod0;
                p1_next = prod1;
                d_next  = prod2;
                state_next = BK_SUM;
            end
            BK_SUM:
            begin
                case (cmd_reg.kind)
                    KIND_MAKE:
                    begin
                        n_next = cmd_reg.an;
                        d_next = cmd_reg.ad;
                    end
                    KIND_ADD: n_next = p0_reg + p1_reg;
                    default:  n_next = p0_reg;
                endcase
                state_next = BK_GCD;
                busy_div_next = 1'b0;
            end
            BK_GCD:
            begin
                if (!raw_ok)
                begin
                    out_next   = 1'b1;
                    on_next    = '1;
                    od_next    = '1;
                    oe_next    = 1'b1;
                    state_next = BK_IDLE;
                end
                else if (n_reg == 64'd0)
                begin
                    rn_next    = 64'd0;
                    gx_next    = d_reg;
                    state_next = BK_DONE;
                end
                else if (!busy_div_reg)
                begin
                    // seed euclid with x = n, y = d
                    gx_next       = n_reg;
                    gy_next       = d_reg;
                    busy_div_next = 1'b1;
                    state_next    = BK_DIVN;
                end
            end
            BK_DIVN:
            begin
                // euclid iteration: x, y <- y, x mod y
                if (gy_reg == 64'd0)
                begin
                    div_a         = n_reg;
                    div_b         = gx_reg;
                    go            = 1'b1;
                    busy_div_next = 1'b0;
                    state_next    = BK_DIVD;
                end
                else if (!busy_div_reg)
                begin
                    if (div_done)
                    begin
                        gx_next       = gy_reg;
                        gy_next       = div_r;
                        busy_div_next = 1'b1;
                    end
                end
                else
                begin
                    go            = 1'b1;
                    busy_div_next = 1'b0;
                end
            end
            BK_DIVD:
            begin
                if (div_done && !busy_div_reg)
                begin
                    rn_next       = div_q;
                    div_a         = d_reg;
                    div_b         = gx_reg;
                    go            = 1'b1;
                    busy_div_next = 1'b1;
                end
                else if (div_done && busy_div_reg)
                begin
                    gx_next    = div_q;
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                out_next   = 1'b1;
                if ((rn_reg[63:31] == '0) && (gx_reg[63:30] == '0))
                begin
                    on_next = rn_reg[31:0];
                    od_next = gx_reg[30:0];
                    oe_next = 1'b0;
                end
                else
                begin
                    on_next = '1;
                    od_next = '1;
                    oe_next = 1'b1;
                end
                state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            out_reg      <= 1'b0;
            busy_div_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            out_reg      <= out_next;
            busy_div_reg <= busy_div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        p0_reg  <= p0_next;
        p1_reg  <= p1_next;
        n_reg   <= n_next;
        d_reg   <= d_next;
        gx_reg  <= gx_next;
        gy_reg  <= gy_next;
        rn_reg  <= rn_next;
        on_reg  <= on_next;
        od_reg  <= od_next;
        oe_reg  <= oe_next;
    end

    assign idle       = (state_reg == BK_IDLE) && !out_reg;
    assign res_strobe = out_reg;
    assign res_num    = on_reg;
    assign res_den    = od_reg;
    assign empty_res  = oe_reg;

    // a result strobe closes every item
    property p_done_to_strobe;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DONE) |=> out_reg;
    endproperty
    a_done_to_strobe: assert property (p_done_to_strobe)
        else $error("done state without result strobe");

    property p_pop_when_idle;
        @(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == BK_IDLE) && q_valid;
    endproperty
    a_pop_when_idle: assert property (p_pop_when_idle)
        else $error("queue popped outside idle");

    property p_empty_pattern;
        @(posedge clk) disable iff (!rst_n)
        (out_reg && oe_reg) |-> (on_reg == '1) && (od_reg == '1);
    endproperty
    a_empty_pattern: assert property (p_empty_pattern)
        else $error("empty result without -1/-1 fields");

endmodule

// ===== rtl/rational_add_mul_reduce.sv =====
// ---------------------------------------------------------------------------
// rational_add_mul_reduce
// fraction make/add/multiply with gcd reduction, and fraction compare
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// its result has been strobed on done, one item at a time. A compare answers
// in the cycle right after its transfer. Arithmetic forms the raw fraction in
// the multiply and sum states, then runs each euclid remainder step and two
// more division passes on the shared 64-bit bit-serial divider; an invalid
// raw fraction or a zero numerator skips the divider. Results cannot be held
// off by the receiver.
module rational_add_mul_reduce
    import rat_pkg::*;
#(
    parameter int OPERAND_BITS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     kind,
    input  logic signed [OPERAND_BITS-1:0] a_num,
    input  logic signed [OPERAND_BITS-1:0] a_den,
    input  logic signed [OPERAND_BITS-1:0] b_num,
    input  logic signed [OPERAND_BITS-1:0] b_den,
    output logic                           done,
    output logic signed [31:0]             res_num,
    output logic signed [30:0]             res_den,
    output logic                           empty_res,
    output logic                           is_equal,
    output logic                           is_not_equal
);

    logic        q_valid;
    cmd_t        q_cmd;
    logic        q_pop;
    logic        back_idle;
    logic        cmp_strobe;
    logic        cmp_eq;
    logic        cmp_ne;
    logic        ar_strobe;
    logic [31:0] ar_num;
    logic [30:0] ar_den;
    logic        ar_empty;

    rat_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .a_num      (a_num),
        .a_den      (a_den),
        .b_num      (b_num),
        .b_den      (b_den),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop),
        .back_idle  (back_idle),
        .cmp_strobe (cmp_strobe),
        .cmp_eq     (cmp_eq),
        .cmp_ne     (cmp_ne)
    );

    rat_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop),
        .idle       (back_idle),
        .res_strobe (ar_strobe),
        .res_num    (ar_num),
        .res_den    (ar_den),
        .empty_res  (ar_empty)
    );

    // merge the two result sources onto the output transfer
    assign done         = cmp_strobe || ar_strobe;
    assign res_num      = ar_strobe ? ar_num : 32'd0;
    assign res_den      = ar_strobe ? ar_den : 31'd0;
    assign empty_res    = ar_strobe ? ar_empty : 1'b0;
    assign is_equal     = cmp_strobe && cmp_eq;
    assign is_not_equal = cmp_strobe && cmp_ne;

    property p_one_source;
        @(posedge clk) disable iff (!rst_n)
        !(cmp_strobe && ar_strobe);
    endproperty
    a_one_source: assert property (p_one_source)
        else $error("two results in one cycle");

    property p_busy_on_start;
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy;
    endproperty
    a_busy_on_start: assert property (p_busy_on_start)
        else $error("not busy after a transfer");

    property p_flags_exclusive;
        @(posedge clk) disable iff (!rst_n)
        !(is_equal && is_not_equal);
    endproperty
    a_flags_exclusive: assert property (p_flags_exclusive)
        else $error("equal and not equal together");

endmodule
